### sv/dott_pkg.sv
package dott_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int TIME_BITS   = 48;
    localparam int ID_BITS     = 16;
    localparam int MAX_FIRE    = 16;
    localparam int IDX_W       = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_EXPIRE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BACKWARDS = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [ID_BITS-1:0]   id_t;

    typedef struct packed {
        id_t   id;
        time_t deadline;
        time_t period;
    } entry_t;

    typedef struct packed {
        id_t   id;
        time_t period;
    } rearm_t;

endpackage

### sv/dott_ram.sv
module dott_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/deadline_ordered_timer_table_core.sv
// Sorted timer table held in a single-port-write, single-port-read RAM, one entry read per
// cycle. Add, delete and expire each walk the table of pending timers, and each re-armed
// periodic timer adds a further insertion walk. Results appear on the result ports for one
// cycle under result_valid and cannot be held off; busy stays high until the command is
// complete, and start is taken only while busy is low.
module deadline_ordered_timer_table_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                cmd,
    input  logic [dott_pkg::ID_BITS-1:0]   target_id,
    input  logic [dott_pkg::TIME_BITS-1:0] deadline,
    input  logic [dott_pkg::TIME_BITS-1:0] period,
    input  logic [dott_pkg::TIME_BITS-1:0] now_time,
    output logic                      result_valid,
    output logic [1:0]                status,
    output logic [dott_pkg::ID_BITS-1:0]   result_id,
    output logic [dott_pkg::TIME_BITS-1:0] result_time,
    output logic                      fired,
    output logic                      new_earliest,
    output logic                      last
);

    import dott_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_CMP  = 4'd1;
    localparam logic [3:0] S_INS_PUT  = 4'd2;
    localparam logic [3:0] S_DEL_SCAN = 4'd3;
    localparam logic [3:0] S_EXP_SCAN = 4'd4;
    localparam logic [3:0] S_EXP_END  = 4'd5;
    localparam logic [3:0] S_RA_RD    = 4'd6;
    localparam logic [3:0] S_RA_LD    = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] bcnt_reg, bcnt_next;
    logic             found_reg, found_next;
    logic             rearm_reg, rearm_next;
    logic             pend_v_reg, pend_v_next;
    entry_t           pend_reg, pend_next;
    entry_t           ins_reg, ins_next;
    time_t            now_reg, now_next;
    time_t            prev_reg, prev_next;
    time_t            earliest_reg, earliest_next;
    id_t              next_id_reg, next_id_next;
    logic [1:0]       status_reg, status_next;
    id_t              rid_reg, rid_next;
    logic             ne_reg, ne_next;

    logic             ov_reg, ov_next;
    logic [1:0]       ostat_reg, ostat_next;
    id_t              oid_reg, oid_next;
    time_t            otime_reg, otime_next;
    logic             ofired_reg, ofired_next;
    logic             one_reg, one_next;
    logic             olast_reg, olast_next;

    logic             t_we;
    logic [IDX_W-1:0] t_waddr, t_raddr;
    entry_t           t_wdata, t_q;
    logic             b_we;
    logic [IDX_W-1:0] b_waddr, b_raddr;
    rearm_t           b_wdata, b_q;

    logic [CNT_W-1:0] cur_inc, cur_dec, cur_mk, cnt_dec, cnt_inc, b_inc;
    time_t            earliest_eff;
    logic             shift_ent, last_one, id_match, fire;
    logic [TIME_BITS:0] rearm_sum;
    time_t            rearm_time;

    dott_ram #(.WIDTH($bits(entry_t)), .DEPTH(TIMER_SLOTS)) u_table (
        .clk     (clk),
        .wr_en   (t_we),
        .wr_addr (t_waddr),
        .wr_data (t_wdata),
        .rd_addr (t_raddr),
        .rd_data (t_q)
    );

    dott_ram #(.WIDTH($bits(rearm_t)), .DEPTH(TIMER_SLOTS)) u_rearm (
        .clk     (clk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (b_wdata),
        .rd_addr (b_raddr),
        .rd_data (b_q)
    );

    assign cur_inc      = cur_reg + CNT_W'(1);
    assign cur_dec      = cur_reg - CNT_W'(1);
    assign cur_mk       = cur_reg - k_reg;
    assign cnt_dec      = cnt_reg - CNT_W'(1);
    assign cnt_inc      = cnt_reg + CNT_W'(1);
    assign b_inc        = b_reg + CNT_W'(1);
    assign earliest_eff = (cnt_reg == '0) ? TIME_MAX : earliest_reg;
    assign shift_ent    = (t_q.deadline > ins_reg.deadline) ||
                          ((t_q.deadline == ins_reg.deadline) && (t_q.id > ins_reg.id));
    assign last_one     = (cur_reg == cnt_dec);
    assign id_match     = (t_q.id == rid_reg);
    assign fire         = (t_q.deadline <= now_reg) && (int'(k_reg) < MAX_FIRE);
    assign rearm_sum    = {1'b0, now_reg} + {1'b0, b_q.period};
    assign rearm_time   = rearm_sum[TIME_BITS] ? TIME_MAX : rearm_sum[TIME_BITS-1:0];

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        k_next        = k_reg;
        b_next        = b_reg;
        bcnt_next     = bcnt_reg;
        found_next    = found_reg;
        rearm_next    = rearm_reg;
        pend_v_next   = pend_v_reg;
        pend_next     = pend_reg;
        ins_next      = ins_reg;
        now_next      = now_reg;
        prev_next     = prev_reg;
        next_id_next  = next_id_reg;
        status_next   = status_reg;
        rid_next      = rid_reg;
        ne_next       = ne_reg;
        ov_next       = 1'b0;
        ostat_next    = ostat_reg;
        oid_next      = oid_reg;
        otime_next    = otime_reg;
        ofired_next   = ofired_reg;
        one_next      = one_reg;
        olast_next    = olast_reg;
        t_we          = 1'b0;
        t_waddr       = '0;
        t_wdata       = ins_reg;
        t_raddr       = '0;
        b_we          = 1'b0;
        b_waddr       = bcnt_reg[IDX_W-1:0];
        b_wdata       = '{id: t_q.id, period: t_q.period};
        b_raddr       = b_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_ADD:
                        begin
                            if (cnt_reg == CNT_W'(TIMER_SLOTS))
                            begin
                                status_next = ST_FULL;
                                rid_next    = '0;
                                ne_next     = 1'b0;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ins_next     = '{id: next_id_reg, deadline: deadline,
                                                 period: period};
                                rid_next     = next_id_reg;
                                ne_next      = (deadline < earliest_eff);
                                status_next  = ST_OK;
                                next_id_next = next_id_reg + ID_BITS'(1);
                                rearm_next   = 1'b0;
                                if (cnt_reg == '0)
                                begin
                                    cur_next   = '0;
                                    state_next = S_INS_PUT;
                                end
                                else
                                begin
                                    t_raddr    = cnt_dec[IDX_W-1:0];
                                    cur_next   = cnt_dec;
                                    state_next = S_INS_CMP;
                                end
                            end
                        end
                        CMD_DELETE:
                        begin
                            rid_next    = target_id;
                            status_next = ST_NOT_FOUND;
                            ne_next     = 1'b0;
                            found_next  = 1'b0;
                            cur_next    = '0;
                            state_next  = (cnt_reg == '0) ? S_DONE : S_DEL_SCAN;
                        end
                        CMD_EXPIRE:
                        begin
                            rid_next = '0;
                            ne_next  = 1'b0;
                            if (now_time < prev_reg)
                            begin
                                status_next = ST_BACKWARDS;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                prev_next   = now_time;
                                now_next    = now_time;
                                k_next      = '0;
                                bcnt_next   = '0;
                                pend_v_next = 1'b0;
                                cur_next    = '0;
                                state_next  = (cnt_reg == '0) ? S_DONE : S_EXP_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                            rid_next    = '0;
                            ne_next     = 1'b0;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            // Walk down from the tail, moving later entries up one slot until the new
            // timer's place is found.
            S_INS_CMP:
            begin
                t_we = 1'b1;
                t_waddr = cur_inc[IDX_W-1:0];
                if (shift_ent)
                begin
                    t_wdata = t_q;
                    if (cur_reg == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        t_raddr  = cur_dec[IDX_W-1:0];
                        cur_next = cur_dec;
                    end
                end
                else
                begin
                    t_wdata  = ins_reg;
                    cnt_next = cnt_inc;
                    if (rearm_reg)
                    begin
                        b_next     = b_inc;
                        state_next = (b_inc == bcnt_reg) ? S_IDLE : S_RA_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_INS_PUT:
            begin
                t_we     = 1'b1;
                t_waddr  = cur_reg[IDX_W-1:0];
                t_wdata  = ins_reg;
                cnt_next = cnt_inc;
                if (rearm_reg)
                begin
                    b_next     = b_inc;
                    state_next = (b_inc == bcnt_reg) ? S_IDLE : S_RA_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Once the match is found, every later entry moves down one slot.
            S_DEL_SCAN:
            begin
                if (found_reg)
                begin
                    t_we    = 1'b1;
                    t_waddr = cur_dec[IDX_W-1:0];
                    t_wdata = t_q;
                end
                else if (id_match)
                begin
                    found_next  = 1'b1;
                    status_next = ST_OK;
                end
                if (last_one)
                begin
                    if (found_reg || id_match)
                    begin
                        cnt_next = cnt_dec;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    t_raddr  = cur_inc[IDX_W-1:0];
                    cur_next = cur_inc;
                end
            end

            // Due timers leave from the head; the rest close up by the number fired.
            // A fired result is held one step so that its last flag is known.
            S_EXP_SCAN:
            begin
                if (fire)
                begin
                    if (pend_v_reg)
                    begin
                        ov_next     = 1'b1;
                        ostat_next  = ST_OK;
                        oid_next    = pend_reg.id;
                        otime_next  = pend_reg.deadline;
                        ofired_next = 1'b1;
                        one_next    = 1'b0;
                        olast_next  = 1'b0;
                    end
                    pend_next   = t_q;
                    pend_v_next = 1'b1;
                    k_next      = k_reg + CNT_W'(1);
                    if (t_q.period != '0)
                    begin
                        b_we      = 1'b1;
                        bcnt_next = bcnt_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    t_we    = 1'b1;
                    t_waddr = cur_mk[IDX_W-1:0];
                    t_wdata = t_q;
                    if (pend_v_reg)
                    begin
                        ov_next     = 1'b1;
                        ostat_next  = ST_OK;
                        oid_next    = pend_reg.id;
                        otime_next  = pend_reg.deadline;
                        ofired_next = 1'b1;
                        one_next    = 1'b0;
                        olast_next  = 1'b1;
                        pend_v_next = 1'b0;
                    end
                end
                if (last_one)
                begin
                    state_next = S_EXP_END;
                end
                else
                begin
                    t_raddr  = cur_inc[IDX_W-1:0];
                    cur_next = cur_inc;
                end
            end

            S_EXP_END:
            begin
                cnt_next = cnt_reg - k_reg;
                if (pend_v_reg)
                begin
                    ov_next     = 1'b1;
                    ostat_next  = ST_OK;
                    oid_next    = pend_reg.id;
                    otime_next  = pend_reg.deadline;
                    ofired_next = 1'b1;
                    one_next    = 1'b0;
                    olast_next  = 1'b1;
                    pend_v_next = 1'b0;
                end
                if (k_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (bcnt_reg != '0)
                begin
                    b_next     = '0;
                    rearm_next = 1'b1;
                    state_next = S_RA_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_RA_RD:
            begin
                b_raddr    = b_reg[IDX_W-1:0];
                state_next = S_RA_LD;
            end

            S_RA_LD:
            begin
                ins_next = '{id: b_q.id, deadline: rearm_time, period: b_q.period};
                if (cnt_reg == '0)
                begin
                    cur_next   = '0;
                    state_next = S_INS_PUT;
                end
                else
                begin
                    t_raddr    = cnt_dec[IDX_W-1:0];
                    cur_next   = cnt_dec;
                    state_next = S_INS_CMP;
                end
            end

            S_DONE:
            begin
                ov_next     = 1'b1;
                ostat_next  = status_reg;
                oid_next    = rid_reg;
                otime_next  = earliest_eff;
                ofired_next = 1'b0;
                one_next    = ne_reg;
                olast_next  = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Slot zero is the earliest deadline whenever the table is not empty.
        earliest_next = (t_we && (t_waddr == '0)) ? t_wdata.deadline : earliest_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            cur_reg      <= '0;
            k_reg        <= '0;
            b_reg        <= '0;
            bcnt_reg     <= '0;
            found_reg    <= 1'b0;
            rearm_reg    <= 1'b0;
            pend_v_reg   <= 1'b0;
            pend_reg     <= '0;
            ins_reg      <= '0;
            now_reg      <= '0;
            prev_reg     <= '0;
            earliest_reg <= TIME_MAX;
            next_id_reg  <= '0;
            status_reg   <= ST_OK;
            rid_reg      <= '0;
            ne_reg       <= 1'b0;
            ov_reg       <= 1'b0;
            ostat_reg    <= ST_OK;
            oid_reg      <= '0;
            otime_reg    <= '0;
            ofired_reg   <= 1'b0;
            one_reg      <= 1'b0;
            olast_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cur_reg      <= cur_next;
            k_reg        <= k_next;
            b_reg        <= b_next;
            bcnt_reg     <= bcnt_next;
            found_reg    <= found_next;
            rearm_reg    <= rearm_next;
            pend_v_reg   <= pend_v_next;
            pend_reg     <= pend_next;
            ins_reg      <= ins_next;
            now_reg      <= now_next;
            prev_reg     <= prev_next;
            earliest_reg <= earliest_next;
            next_id_reg  <= next_id_next;
            status_reg   <= status_next;
            rid_reg      <= rid_next;
            ne_reg       <= ne_next;
            ov_reg       <= ov_next;
            ostat_reg    <= ostat_next;
            oid_reg      <= oid_next;
            otime_reg    <= otime_next;
            ofired_reg   <= ofired_next;
            one_reg      <= one_next;
            olast_reg    <= olast_next;
        end
    end

    assign result_valid = ov_reg;
    assign status       = ostat_reg;
    assign result_id    = oid_reg;
    assign result_time  = otime_reg;
    assign fired        = ofired_reg;
    assign new_earliest = one_reg;
    assign last         = olast_reg;

endmodule

### sv/dott_checker.sv
module dott_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           result_valid,
    input logic [1:0]                     status,
    input logic                           fired,
    input logic                           new_earliest,
    input logic                           last
);

    import dott_pkg::*;

    // Every accepted request keeps the block busy for at least the following cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after an accepted request");

    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && fired |-> status == ST_OK)
        else $error("fired result carries an error status");

    a_not_last_fired: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> fired)
        else $error("only fired results may be followed by more results");

    a_new_earliest: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && new_earliest |-> !fired && last && status == ST_OK)
        else $error("new_earliest outside a successful add result");

endmodule

bind deadline_ordered_timer_table_core dott_checker u_dott_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .fired        (fired),
    .new_earliest (new_earliest),
    .last         (last)
);
